// ===== src/crs_pkg.sv =====
// Package for the clip rectangle stack: sizes, opcodes, status codes, types.
package crs_pkg;

  localparam int unsigned StackDepth  = 32;
  localparam int unsigned TargetDepth = 8;
  localparam int unsigned FracBits    = 8;
  localparam int unsigned IdxW        = $clog2(StackDepth + 1);
  localparam int unsigned AddrW       = $clog2(StackDepth);
  localparam int unsigned TgtW        = $clog2(TargetDepth + 1);
  localparam int unsigned TgtAddrW    = (TargetDepth > 1) ? $clog2(TargetDepth) : 1;

  localparam logic [2:0] OpPushClip   = 3'd0;
  localparam logic [2:0] OpPopClip    = 3'd1;
  localparam logic [2:0] OpPushTarget = 3'd2;
  localparam logic [2:0] OpPopTarget  = 3'd3;
  localparam logic [2:0] OpScissor    = 3'd4;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StOverflow  = 2'd1;
  localparam logic [1:0] StUnderflow = 2'd2;

  localparam logic [1:0] CfgVpX = 2'd0;
  localparam logic [1:0] CfgVpY = 2'd1;
  localparam logic [1:0] CfgVpW = 2'd2;
  localparam logic [1:0] CfgVpH = 2'd3;

  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] OneQ16 = 32'sh0001_0000;

  typedef struct packed {
    logic signed [31:0] l;
    logic signed [31:0] t;
    logic signed [31:0] r;
    logic signed [31:0] b;
  } rect_t;

  function automatic logic signed [31:0] smin(logic signed [31:0] a, logic signed [31:0] b);
    smin = (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] smax(logic signed [31:0] a, logic signed [31:0] b);
    smax = (a > b) ? a : b;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) sat32 = IntMax;
    else if (v < -34'sh0_8000_0000) sat32 = IntMin;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] px_floor(logic signed [31:0] v);
    logic [31:0] m;
    m = ~((32'd1 << FracBits) - 32'd1);
    px_floor = v & m;
  endfunction

  function automatic logic signed [31:0] px_ceil(logic signed [31:0] v);
    logic signed [32:0] s;
    s = {v[31], v} + 33'sd1 * $signed({1'b0, (32'd1 << FracBits) - 32'd1});
    if (s > 33'sh0_7FFF_FFFF) px_ceil = IntMax;
    else px_ceil = px_floor(s[31:0]);
  endfunction

  function automatic logic signed [31:0] px_trunc(logic signed [31:0] v);
    if (!v[31] || v == IntMin) px_trunc = px_floor(v);
    else px_trunc = -px_floor(-v);
  endfunction

endpackage

// ===== src/crs_mapper.sv =====
// Corner mapper: one shared 32x32 multiplier runs the sixteen corner products.
module crs_mapper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  crs_pkg::rect_t      rect_i,
  input  logic signed [31:0]  m11_i,
  input  logic signed [31:0]  m12_i,
  input  logic signed [31:0]  m21_i,
  input  logic signed [31:0]  m22_i,
  input  logic signed [31:0]  dx_i,
  input  logic signed [31:0]  dy_i,
  output logic                done_o,
  output crs_pkg::rect_t      box_o
);

  // step: corner (2b), axis (1b), term (1b)
  logic [4:0]         step_q, step_d;
  logic               busy_q, busy_d;
  logic               pvld_q;
  logic [3:0]         pstep_q;
  logic signed [63:0] prod_q;
  logic signed [64:0] acc_q, acc_d;
  crs_pkg::rect_t     box_q, box_d;
  logic               done_q;

  logic [1:0]         corner;
  logic               axis, term;
  logic signed [31:0] opa, opb;
  logic signed [64:0] sum;
  logic signed [48:0] flo;
  logic signed [31:0] tr;
  logic signed [49:0] val;
  logic signed [31:0] res;
  logic               first;

  assign corner = step_q[3:2];
  assign axis   = step_q[1];
  assign term   = step_q[0];

  always_comb begin
    opa = term ? ((corner[1]) ? rect_i.b : rect_i.t) : ((corner[0]) ? rect_i.r : rect_i.l);
    case ({axis, term})
      2'b00:   opb = m11_i;
      2'b01:   opb = m21_i;
      2'b10:   opb = m12_i;
      default: opb = m22_i;
    endcase
  end

  always_comb begin
    sum = acc_q + {prod_q[63], prod_q};
    flo = sum[64:16];
    tr  = pstep_q[1] ? dy_i : dx_i;
    val = {flo[48], flo} + {{18{tr[31]}}, tr};
    if (val > 50'sh0_0000_7FFF_FFFF) res = crs_pkg::IntMax;
    else if (val < -50'sh0_0000_8000_0000) res = crs_pkg::IntMin;
    else res = val[31:0];
    first = (pstep_q[3:2] == 2'd0);
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    acc_d  = acc_q;
    box_d  = box_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (step_q == 5'd15) busy_d = 1'b0;
      step_d = step_q + 5'd1;
    end
    if (pvld_q) begin
      if (!pstep_q[0]) begin
        acc_d = {prod_q[63], prod_q};
      end else if (!pstep_q[1]) begin
        box_d.l = first ? res : crs_pkg::smin(box_q.l, res);
        box_d.r = first ? res : crs_pkg::smax(box_q.r, res);
      end else begin
        box_d.t = first ? res : crs_pkg::smin(box_q.t, res);
        box_d.b = first ? res : crs_pkg::smax(box_q.b, res);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      pvld_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      pvld_q <= busy_q && !start_i;
      done_q <= pvld_q && (pstep_q == 4'd15);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= opa * opb;
    pstep_q <= step_q[3:0];
    acc_q   <= acc_d;
    box_q   <= box_d;
  end

  assign done_o = done_q;
  assign box_o  = box_q;

endmodule

// ===== src/clip_rect_stack.sv =====
// Top level of the clip rectangle stack.
// Input channel s_axis_*: one transaction per operation. tuser carries op and
// clip_unbounded; tdata carries the clip corners and the transform.
// Output channel m_axis_*: one transaction per operation with the current top
// (or the scissor), frame depth and status.
// Configuration channel cfg_*: register index and data, writes the viewport.
// Pop, target, scissor, unknown, overflowing and identity or unbounded push
// operations raise m_axis_tvalid in SResp after SRead reads the rectangle memory,
// SCalc updates the stack, SRd2 re-reads the new top and SOut registers the result.
// A transformed push_clip runs its 16 corner products through one shared
// multiplier in SMap, between SRead and SCalc.
// s_axis_tready is low from accept until the cycle after the result is taken,
// so one operation is in flight at a time. A stalled receiver holds the result
// and the input.
// Reset empties the stack and the saved frames and zeroes the viewport; the
// rectangle memory is not cleared and needs no clearing pass.
module clip_rect_stack (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [319:0] s_axis_tdata,  // clip_left, clip_top, clip_right, clip_bottom,
                                      // xform_m11, m12, m21, m22, dx, dy
  input  logic [3:0]   s_axis_tuser,  // op[2:0], clip_unbounded
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // out_left, out_top, out_right, out_bottom,
                                      // frame_depth, status
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1;
  localparam logic [2:0] SMap  = 3'd2;
  localparam logic [2:0] SCalc = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;
  localparam logic [2:0] SRd2  = 3'd5;
  localparam logic [2:0] SResp = 3'd6;

  logic [2:0] state_q, state_d;

  logic [crs_pkg::IdxW-1:0]     top_q, top_d, base_q, base_d;
  logic [crs_pkg::TgtW-1:0]     scnt_q, scnt_d;
  logic [crs_pkg::IdxW-1:0]     saved_mem [crs_pkg::TargetDepth];
  logic [63:0]                  horiz_mem [crs_pkg::StackDepth];
  logic [63:0]                  vert_mem  [crs_pkg::StackDepth];
  logic [63:0]                  hrd_q, vrd_q;
  logic [crs_pkg::IdxW-1:0]     sbrd_q;

  logic signed [31:0] vpx_q, vpy_q;
  logic [30:0]        vpw_q, vph_q;

  logic [2:0]          op_q;
  logic                unb_q;
  logic [319:0]        in_q;
  crs_pkg::rect_t      top_rect, box, res_q, res_d, pushr;
  logic [1:0]          st_q, st_d;
  logic                identity, map_start, map_done;
  logic                ovf_push;
  logic                mem_we;

  // tdata lowest field is clip_left; rect_t packs l highest
  crs_pkg::rect_t clip_r;
  assign clip_r.l = in_q[31:0];
  assign clip_r.t = in_q[63:32];
  assign clip_r.r = in_q[95:64];
  assign clip_r.b = in_q[127:96];

  assign identity = in_q[159:128] == crs_pkg::OneQ16 && in_q[191:160] == '0 &&
                    in_q[223:192] == '0 && in_q[255:224] == crs_pkg::OneQ16 &&
                    in_q[287:256] == '0 && in_q[319:288] == '0;

  crs_mapper u_mapper (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (map_start),
    .rect_i  (clip_r),
    .m11_i   (in_q[159:128]),
    .m12_i   (in_q[191:160]),
    .m21_i   (in_q[223:192]),
    .m22_i   (in_q[255:224]),
    .dx_i    (in_q[287:256]),
    .dy_i    (in_q[319:288]),
    .done_o  (map_done),
    .box_o   (box)
  );

  always_comb begin
    if (top_q == base_q || top_q == '0) begin
      top_rect = '{crs_pkg::IntMin, crs_pkg::IntMin, crs_pkg::IntMax, crs_pkg::IntMax};
    end else begin
      top_rect.l = hrd_q[63:32];
      top_rect.r = hrd_q[31:0];
      top_rect.t = vrd_q[63:32];
      top_rect.b = vrd_q[31:0];
    end
  end

  // push result from top_rect and mapped box (or clip itself when identity, top_rect when unbounded); scissor rect
  crs_pkg::rect_t o;
  logic signed [31:0] vr, vb;
  crs_pkg::rect_t sc;
  always_comb begin
    o = identity ? clip_r : box;
    pushr.l = crs_pkg::px_floor(crs_pkg::smin(crs_pkg::smax(top_rect.l, o.l), top_rect.r));
    pushr.t = crs_pkg::px_floor(crs_pkg::smin(crs_pkg::smax(top_rect.t, o.t), top_rect.b));
    pushr.r = crs_pkg::px_ceil(crs_pkg::smax(crs_pkg::smin(top_rect.r, o.r), top_rect.l));
    pushr.b = crs_pkg::px_ceil(crs_pkg::smax(crs_pkg::smin(top_rect.b, o.b), top_rect.t));
    if (unb_q) pushr = top_rect;
    vr = crs_pkg::sat32({{2{vpx_q[31]}}, vpx_q} + {3'b0, vpw_q});
    vb = crs_pkg::sat32({{2{vpy_q[31]}}, vpy_q} + {3'b0, vph_q});
    sc.l = crs_pkg::smax(crs_pkg::smax(top_rect.l, '0), vpx_q);
    sc.t = crs_pkg::smax(crs_pkg::smax(top_rect.t, '0), vpy_q);
    sc.r = crs_pkg::smin(crs_pkg::smax(top_rect.r, '0), vr);
    sc.b = crs_pkg::smin(crs_pkg::smax(top_rect.b, '0), vb);
    sc.l = crs_pkg::smin(sc.l, sc.r);
    sc.t = crs_pkg::smin(sc.t, sc.b);
    sc.l = crs_pkg::px_trunc(sc.l);
    sc.t = crs_pkg::px_trunc(sc.t);
    sc.r = crs_pkg::px_trunc(sc.r);
    sc.b = crs_pkg::px_trunc(sc.b);
  end

  assign ovf_push = top_q >= crs_pkg::IdxW'(crs_pkg::StackDepth);

  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    base_d    = base_q;
    scnt_d    = scnt_q;
    res_d     = res_q;
    st_d      = st_q;
    map_start = 1'b0;
    mem_we    = 1'b0;
    case (state_q)
      SIdle: begin
        if (s_axis_tvalid) state_d = SRead;
      end
      SRead: begin
        // memory read of current top settles in hrd_q/vrd_q
        st_d = crs_pkg::StOk;
        if (op_q == crs_pkg::OpPushClip && !ovf_push && !unb_q && !identity) begin
          map_start = 1'b1;
          state_d   = SMap;
        end else begin
          state_d = SCalc;
        end
      end
      SMap: begin
        if (map_done) state_d = SCalc;
      end
      SCalc: begin
        state_d = SRd2;
        case (op_q)
          crs_pkg::OpPushClip: begin
            if (ovf_push) st_d = crs_pkg::StOverflow;
            else begin
              mem_we = 1'b1;
              top_d  = top_q + 1'b1;
            end
          end
          crs_pkg::OpPopClip: begin
            if (top_q <= base_q) st_d = crs_pkg::StUnderflow;
            else top_d = top_q - 1'b1;
          end
          crs_pkg::OpPushTarget: begin
            if (scnt_q >= crs_pkg::TgtW'(crs_pkg::TargetDepth)) st_d = crs_pkg::StOverflow;
            else begin
              scnt_d = scnt_q + 1'b1;
              base_d = top_q;
            end
          end
          crs_pkg::OpPopTarget: begin
            if (scnt_q == '0) st_d = crs_pkg::StUnderflow;
            else begin
              scnt_d = scnt_q - 1'b1;
              top_d  = base_q;
              base_d = sbrd_q;
            end
          end
          default: ;
        endcase
      end
      SRd2: begin
        // re-read new top
        state_d = SOut;
      end
      SOut: begin
        res_d = (op_q == crs_pkg::OpScissor) ? sc : top_rect;
        state_d = SResp;
      end
      SResp: begin
        if (m_axis_tready) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // res register loads in SOut; output valid in SResp
  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = (state_q == SResp);
  assign m_axis_tdata  = {st_q, 6'(top_q - base_q),
                          res_q.b, res_q.r, res_q.t, res_q.l};
  assign cfg_ready_o   = 1'b1;

  logic [crs_pkg::AddrW-1:0] raddr;
  assign raddr = crs_pkg::AddrW'(top_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q  <= s_axis_tdata;
      op_q  <= s_axis_tuser[2:0];
      unb_q <= s_axis_tuser[3];
    end
    hrd_q  <= horiz_mem[raddr];
    vrd_q  <= vert_mem[raddr];
    sbrd_q <= saved_mem[crs_pkg::TgtAddrW'(scnt_q - 1'b1)];
    if (mem_we) begin
      horiz_mem[crs_pkg::AddrW'(top_q)] <= {pushr.l, pushr.r};
      vert_mem[crs_pkg::AddrW'(top_q)]  <= {pushr.t, pushr.b};
    end
    if (state_q == SCalc && op_q == crs_pkg::OpPushTarget &&
        scnt_q < crs_pkg::TgtW'(crs_pkg::TargetDepth)) begin
      saved_mem[crs_pkg::TgtAddrW'(scnt_q)] <= base_q;
    end
    res_q <= res_d;
    st_q  <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      top_q   <= '0;
      base_q  <= '0;
      scnt_q  <= '0;
      vpx_q   <= '0;
      vpy_q   <= '0;
      vpw_q   <= '0;
      vph_q   <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      base_q  <= base_d;
      scnt_q  <= scnt_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          crs_pkg::CfgVpX: vpx_q <= cfg_data_i;
          crs_pkg::CfgVpY: vpy_q <= cfg_data_i;
          crs_pkg::CfgVpW: vpw_q <= cfg_data_i[30:0];
          crs_pkg::CfgVpH: vph_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for clip_rect_stack: random and directed clip stack traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OpFirstUnused = 3'd5;
  localparam logic [2:0] OpMidUnused   = 3'd6;
  localparam logic [2:0] OpLastUnused  = 3'd7;
  localparam int unsigned PhaseItems   = 250;

  typedef struct {
    logic [2:0]         op;
    logic               unbounded;
    logic signed [31:0] l, t, r, b;
    logic signed [31:0] m11, m12, m21, m22, dx, dy;
  } clip_cmd_t;

  typedef struct {
    crs_pkg::rect_t rect;
    logic [5:0]     depth;
    logic [1:0]     status;
  } stack_reply_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  clip_rect_stack dut (.*);

  // predictor state
  crs_pkg::rect_t     clip_mem [crs_pkg::StackDepth];
  int unsigned        top_idx, base_idx, saved_cnt;
  int unsigned        saved_base [crs_pkg::TargetDepth];
  logic signed [31:0] vp_x, vp_y;
  logic [30:0]        vp_w, vp_h;

  clip_cmd_t    pending_cmds [$];
  stack_reply_t expected_replies [$];
  clip_cmd_t    cur_cmd;
  int unsigned  send_gap, recv_stall, mismatches;
  bit           jitter, recv_hold, hold_go;

  initial forever #4 clk_i = ~clk_i;

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return crs_pkg::IntMax;
    if (v < -66'sh8000_0000) return crs_pkg::IntMin;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] lo(logic signed [31:0] a, logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] hi(logic signed [31:0] a, logic signed [31:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [31:0] snap_down(logic signed [31:0] v);
    return v & ~((32'd1 << crs_pkg::FracBits) - 1);
  endfunction

  function automatic logic signed [31:0] snap_up(logic signed [31:0] v);
    logic signed [32:0] s;
    s = {v[31], v} + 33'sd255;
    if (s > 33'sh7FFF_FFFF) return crs_pkg::IntMax;
    return snap_down(s[31:0]);
  endfunction

  function automatic logic signed [31:0] snap_zero(logic signed [31:0] v);
    if (!v[31] || v == crs_pkg::IntMin) return snap_down(v);
    return -snap_down(-v);
  endfunction

  function automatic logic signed [65:0] dot_q16(logic signed [31:0] a, logic signed [31:0] ma,
                                                  logic signed [31:0] b, logic signed [31:0] mb);
    logic signed [65:0] s;
    s = a * ma + b * mb;
    return s >>> 16;
  endfunction

  function automatic crs_pkg::rect_t top_rect();
    if (top_idx == base_idx || top_idx == 0)
      return '{crs_pkg::IntMin, crs_pkg::IntMin, crs_pkg::IntMax, crs_pkg::IntMax};
    return clip_mem[top_idx - 1];
  endfunction

  function automatic crs_pkg::rect_t narrowed_clip(clip_cmd_t c, crs_pkg::rect_t e);
    crs_pkg::rect_t o, res;
    logic signed [31:0] xs [4], ys [4], cx, cy;
    if (c.unbounded) return e;
    o = '{c.l, c.t, c.r, c.b};
    if (!(c.m11 == crs_pkg::OneQ16 && c.m12 == 0 && c.m21 == 0 && c.m22 == crs_pkg::OneQ16 &&
          c.dx == 0 && c.dy == 0)) begin
      for (int i = 0; i < 4; i++) begin
        cx = i[0] ? c.r : c.l;
        cy = i[1] ? c.b : c.t;
        xs[i] = clamp32(dot_q16(cx, c.m11, cy, c.m21) + c.dx);
        ys[i] = clamp32(dot_q16(cx, c.m12, cy, c.m22) + c.dy);
      end
      o = '{xs[0], ys[0], xs[0], ys[0]};
      for (int i = 1; i < 4; i++) begin
        o.l = lo(o.l, xs[i]); o.r = hi(o.r, xs[i]);
        o.t = lo(o.t, ys[i]); o.b = hi(o.b, ys[i]);
      end
    end
    res.l = snap_down(lo(hi(e.l, o.l), e.r));
    res.t = snap_down(lo(hi(e.t, o.t), e.b));
    res.r = snap_up(hi(lo(e.r, o.r), e.l));
    res.b = snap_up(hi(lo(e.b, o.b), e.t));
    return res;
  endfunction

  function automatic crs_pkg::rect_t scissor_rect();
    crs_pkg::rect_t r;
    logic signed [31:0] vr, vb;
    r  = top_rect();
    vr = clamp32(vp_x + $signed({35'd0, vp_w}));
    vb = clamp32(vp_y + $signed({35'd0, vp_h}));
    r.l = hi(hi(r.l, 0), vp_x); r.t = hi(hi(r.t, 0), vp_y);
    r.r = lo(hi(r.r, 0), vr);   r.b = lo(hi(r.b, 0), vb);
    r.l = lo(r.l, r.r); r.t = lo(r.t, r.b);
    return '{snap_zero(r.l), snap_zero(r.t), snap_zero(r.r), snap_zero(r.b)};
  endfunction

  function automatic stack_reply_t apply_cmd(clip_cmd_t c);
    stack_reply_t y;
    y.status = crs_pkg::StOk;
    case (c.op)
      crs_pkg::OpPushClip: begin
        if (top_idx >= crs_pkg::StackDepth) y.status = crs_pkg::StOverflow;
        else begin
          clip_mem[top_idx] = narrowed_clip(c, top_rect());
          top_idx++;
        end
      end
      crs_pkg::OpPopClip: begin
        if (top_idx <= base_idx) y.status = crs_pkg::StUnderflow;
        else top_idx--;
      end
      crs_pkg::OpPushTarget: begin
        if (saved_cnt >= crs_pkg::TargetDepth) y.status = crs_pkg::StOverflow;
        else begin
          saved_base[saved_cnt++] = base_idx;
          base_idx = top_idx;
        end
      end
      crs_pkg::OpPopTarget: begin
        if (saved_cnt == 0) y.status = crs_pkg::StUnderflow;
        else begin
          top_idx  = base_idx;
          base_idx = saved_base[--saved_cnt];
        end
      end
      default: ;
    endcase
    y.rect  = (c.op == crs_pkg::OpScissor) ? scissor_rect() : top_rect();
    y.depth = 6'(top_idx - base_idx);
    return y;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_replies.insert(expected_replies.size(), apply_cmd(cur_cmd));
        send_gap = jitter ? $urandom_range(0, 3) : 0;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap == 0 && pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_cmd.dy, cur_cmd.dx, cur_cmd.m22, cur_cmd.m21,
                            cur_cmd.m12, cur_cmd.m11, cur_cmd.b, cur_cmd.r, cur_cmd.t, cur_cmd.l};
          s_axis_tuser  <= {cur_cmd.unbounded, cur_cmd.op};
        end else begin
          s_axis_tvalid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    stack_reply_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          report("unexpected transaction", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tdata[31:0] !== want.rect.l) report("left", m_axis_tdata[31:0], want.rect.l);
          if (m_axis_tdata[63:32] !== want.rect.t) report("top", m_axis_tdata[63:32], want.rect.t);
          if (m_axis_tdata[95:64] !== want.rect.r) report("right", m_axis_tdata[95:64], want.rect.r);
          if (m_axis_tdata[127:96] !== want.rect.b)
            report("bottom", m_axis_tdata[127:96], want.rect.b);
          if (m_axis_tdata[133:128] !== want.depth)
            report("frame_depth", 32'(m_axis_tdata[133:128]), 32'(want.depth));
          if (m_axis_tdata[135:134] !== want.status)
            report("status", 32'(m_axis_tdata[135:134]), 32'(want.status));
        end
        recv_stall = jitter ? $urandom_range(0, 3) : 0;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !recv_hold;
      end
    end
  end

  // long receiver hold-off
  initial begin
    recv_hold = 1'b0;
    wait (hold_go);
    recv_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return crs_pkg::IntMin + $urandom_range(0, 600);
      2:       return crs_pkg::IntMax - $urandom_range(0, 600);
      default: return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_term(logic signed [31:0] center);
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 0;
      default: return center + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic clip_cmd_t make_cmd(logic [2:0] op);
    clip_cmd_t c;
    c.op = op;
    c.unbounded = ($urandom_range(0, 6) == 0);
    c.l = rand_coord(); c.t = rand_coord(); c.r = rand_coord(); c.b = rand_coord();
    if ($urandom_range(0, 4) == 0) begin
      c.m11 = crs_pkg::OneQ16; c.m12 = 0; c.m21 = 0; c.m22 = crs_pkg::OneQ16;
      c.dx = 0; c.dy = 0;
    end else begin
      c.m11 = rand_term($urandom_range(0, 1) ? crs_pkg::OneQ16 : -crs_pkg::OneQ16);
      c.m12 = rand_term(0);
      c.m21 = rand_term(0);
      c.m22 = rand_term($urandom_range(0, 1) ? crs_pkg::OneQ16 : -crs_pkg::OneQ16);
      c.dx = rand_coord(); c.dy = rand_coord();
    end
    return c;
  endfunction

  function automatic logic [2:0] pick_op(int unsigned mix);
    int unsigned w;
    w = $urandom_range(0, 99);
    case (mix)
      1: return (w < 70) ? crs_pkg::OpPushClip : (w < 80) ? crs_pkg::OpPopClip :
                (w < 92) ? crs_pkg::OpScissor : crs_pkg::OpPopTarget;
      2: return (w < 35) ? crs_pkg::OpPushTarget : (w < 50) ? crs_pkg::OpPopTarget :
                (w < 75) ? crs_pkg::OpPushClip : (w < 88) ? crs_pkg::OpPopClip :
                crs_pkg::OpScissor;
      default: return (w < 35) ? crs_pkg::OpPushClip : (w < 55) ? crs_pkg::OpPopClip :
                      (w < 65) ? crs_pkg::OpPushTarget : (w < 75) ? crs_pkg::OpPopTarget :
                      (w < 95) ? crs_pkg::OpScissor :
                      3'($urandom_range(OpFirstUnused, OpLastUnused));
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_replies.size() > 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i);
    while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      crs_pkg::CfgVpX: vp_x = val;
      crs_pkg::CfgVpY: vp_y = val;
      crs_pkg::CfgVpW: vp_w = val[30:0];
      default:         vp_h = val[30:0];
    endcase
  endtask

  task automatic set_viewport(logic [31:0] x, logic [31:0] y, logic [31:0] w, logic [31:0] h);
    write_reg(crs_pkg::CfgVpX, x);
    write_reg(crs_pkg::CfgVpY, y);
    write_reg(crs_pkg::CfgVpW, w);
    write_reg(crs_pkg::CfgVpH, h);
  endtask

  task automatic add_cmd(logic [2:0] op, logic signed [31:0] l, logic signed [31:0] t,
                         logic signed [31:0] r, logic signed [31:0] b, logic unb,
                         logic signed [31:0] m11, logic signed [31:0] m22,
                         logic signed [31:0] shear, logic signed [31:0] d);
    clip_cmd_t c;
    c = '{op, unb, l, t, r, b, m11, shear, shear, m22, d, d};
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  initial begin
    top_idx = 0; base_idx = 0; saved_cnt = 0;
    vp_x = 0; vp_y = 0; vp_w = 0; vp_h = 0;
    mismatches = 0; jitter = 1'b1; hold_go = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    add_cmd(crs_pkg::OpPopClip, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPopTarget, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpScissor, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushClip, crs_pkg::IntMin, crs_pkg::IntMin, crs_pkg::IntMax,
            crs_pkg::IntMax, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushClip, 32'sh1234, -32'sh0F01, 32'sh0001_0001, 32'sh80FF, 0,
            crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushClip, 100, 200, 50, 10, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushClip, 0, 0, 0, 0, 1, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushTarget, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushClip, crs_pkg::IntMin, crs_pkg::IntMin, crs_pkg::IntMax,
            crs_pkg::IntMax, 0, crs_pkg::IntMax, crs_pkg::IntMin, crs_pkg::IntMin,
            crs_pkg::IntMax);
    add_cmd(crs_pkg::OpPushClip, -32'sh1000, -32'sh1000, 32'sh1000, 32'sh1000, 0,
            -crs_pkg::OneQ16, 2 * crs_pkg::OneQ16, 32'sh8000, crs_pkg::IntMin);
    add_cmd(crs_pkg::OpScissor, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPushClip, crs_pkg::IntMax - 5, crs_pkg::IntMax - 5, crs_pkg::IntMax,
            crs_pkg::IntMax, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(OpFirstUnused, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(OpMidUnused, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(OpLastUnused, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPopClip, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpPopTarget, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    add_cmd(crs_pkg::OpScissor, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    for (int i = 0; i < 9; i++)
      add_cmd(crs_pkg::OpPushTarget, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    for (int i = 0; i < 9; i++)
      add_cmd(crs_pkg::OpPopTarget, 0, 0, 0, 0, 0, crs_pkg::OneQ16, crs_pkg::OneQ16, 0, 0);
    wait_idle();

    // random phases, each under its own viewport
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_viewport(32'h0000_1080, 32'h0000_0F40, 32'h0004_0000, 32'h0003_0000);
        1: set_viewport(crs_pkg::IntMin, crs_pkg::IntMin, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        2: set_viewport(crs_pkg::IntMax, crs_pkg::IntMax, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        3: set_viewport(0, 0, 0, 0);
        default: set_viewport($urandom(), $urandom(), $urandom(), $urandom());
      endcase
      jitter = (ph != 3);
      for (int n = 0; n < PhaseItems; n++) begin
        pending_cmds.insert(pending_cmds.size(), make_cmd(pick_op(ph % 3)));
        if (n == PhaseItems / 2) begin
          if (ph == 1) hold_go = 1'b1;
          wait_idle();
        end
      end
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
